FILE: hw/rtl/eafr_pkg.sv
package eafr_pkg;

  // Receiver framing phase
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  // Token classes passed from the front to the back
  typedef enum logic [1:0] {
    TOK_START = 2'd0,
    TOK_BODY  = 2'd1,
    TOK_CHECK = 2'd2
  } tok_kind_t;

  // Result kinds as seen on the result port
  typedef enum logic [1:0] {
    KIND_PAYLOAD     = 2'd0,
    KIND_MSG_GOOD    = 2'd1,
    KIND_STATUS_GOOD = 2'd2,
    KIND_CSUM_BAD    = 2'd3
  } kind_t;

  localparam int unsigned PLEN_W = 7;
  localparam int unsigned POS_W  = 4;

  typedef struct packed {
    tok_kind_t         kind;
    logic [7:0]        value;
    logic [PLEN_W-1:0] plen;
  } token_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         payload_byte;
    logic signed [7:0]  signal_strength;
    logic [PLEN_W-1:0]  payload_length;
    logic [7:0]         ack_frame_id;
    logic [7:0]         delivery_status;
  } result_t;

  localparam logic [7:0] START_MARK  = 8'h7E;
  localparam logic [7:0] ESC_MARK    = 8'h7D;
  localparam logic [7:0] XON_MARK    = 8'h11;
  localparam logic [7:0] XOFF_MARK   = 8'h13;
  localparam logic [7:0] FLIP_MASK   = 8'h20;
  localparam logic [7:0] CSUM_BASE   = 8'hFF;
  localparam logic [7:0] TYPE_RX     = 8'h80;
  localparam logic [7:0] TYPE_STATUS = 8'h89;

  localparam logic [15:0]       RX_OVERHEAD = 16'd11;
  localparam logic [PLEN_W-1:0] PLEN_MAX    = 7'd127;

  localparam logic [POS_W-1:0] POS_TYPE    = 4'd0;
  localparam logic [POS_W-1:0] POS_ID      = 4'd1;
  localparam logic [POS_W-1:0] POS_STATUS  = 4'd2;
  localparam logic [POS_W-1:0] POS_RSSI    = 4'd9;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 4'd11;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

FILE: hw/rtl/eafr_fifo.sv
module eafr_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/eafr_front.sv
module eafr_front #(
  parameter int unsigned MAX_FRAME = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output logic                 tok_valid,
  output eafr_pkg::token_t     tok
);

  localparam int unsigned LEN_W = $clog2(MAX_FRAME + 1);

  eafr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             esc_r, esc_nxt;

  logic [15:0] frame_len;
  logic        too_long;
  logic        is_mark;
  logic [7:0]  value;
  logic [15:0] plen_diff;
  logic [eafr_pkg::PLEN_W-1:0] plen;

  assign frame_len = {len_hi_r, rx_byte};
  assign too_long  = ({1'b0, frame_len} > 17'(MAX_FRAME));
  assign is_mark   = (rx_byte == eafr_pkg::START_MARK) || (rx_byte == eafr_pkg::ESC_MARK) ||
                     (rx_byte == eafr_pkg::XON_MARK) || (rx_byte == eafr_pkg::XOFF_MARK);
  assign value     = esc_r ? (rx_byte ^ eafr_pkg::FLIP_MASK) : rx_byte;
  assign plen_diff = frame_len - eafr_pkg::RX_OVERHEAD;

  // Payload length: frame length less header, floored at zero, capped at 127
  always_comb begin
    if (frame_len <= eafr_pkg::RX_OVERHEAD) begin
      plen = '0;
    end else if (plen_diff > 16'(eafr_pkg::PLEN_MAX)) begin
      plen = eafr_pkg::PLEN_MAX;
    end else begin
      plen = plen_diff[eafr_pkg::PLEN_W-1:0];
    end
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        eafr_pkg::PH_HUNT: begin
          if (rx_byte == eafr_pkg::START_MARK) phase_nxt = eafr_pkg::PH_LEN_HI;
        end
        eafr_pkg::PH_LEN_HI: begin
          phase_nxt = eafr_pkg::PH_LEN_LO;
        end
        eafr_pkg::PH_LEN_LO: begin
          phase_nxt = too_long ? eafr_pkg::PH_HUNT : eafr_pkg::PH_BODY;
        end
        eafr_pkg::PH_BODY: begin
          if ((esc_r || !is_mark) && (bytes_left_r == '0)) phase_nxt = eafr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Datapath and token output
  always_comb begin
    len_hi_nxt     = len_hi_r;
    bytes_left_nxt = bytes_left_r;
    esc_nxt        = esc_r;
    tok_valid      = 1'b0;
    tok.kind       = eafr_pkg::TOK_BODY;
    tok.value      = value;
    tok.plen       = plen;
    if (accept) begin
      unique case (phase_r)
        eafr_pkg::PH_HUNT: begin
        end
        eafr_pkg::PH_LEN_HI: begin
          len_hi_nxt = rx_byte;
        end
        eafr_pkg::PH_LEN_LO: begin
          if (!too_long) begin
            bytes_left_nxt = frame_len[LEN_W-1:0];
            esc_nxt        = 1'b0;
            tok_valid      = 1'b1;
            tok.kind       = eafr_pkg::TOK_START;
          end
        end
        eafr_pkg::PH_BODY: begin
          if (!esc_r && is_mark) begin
            esc_nxt = 1'b1;
          end else begin
            esc_nxt   = 1'b0;
            tok_valid = 1'b1;
            if (bytes_left_r != '0) begin
              bytes_left_nxt = bytes_left_r - 1'b1;
              tok.kind       = eafr_pkg::TOK_BODY;
            end else begin
              tok.kind = eafr_pkg::TOK_CHECK;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= eafr_pkg::PH_HUNT;
      bytes_left_r <= '0;
      esc_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      esc_r        <= esc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_hi_r <= len_hi_nxt;
  end

endmodule

FILE: hw/rtl/eafr_back.sv
module eafr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_take,
  input  eafr_pkg::token_t  tok,
  output logic              res_valid,
  output eafr_pkg::result_t res
);

  logic [7:0]                  sum_r, sum_nxt;
  logic [7:0]                  type_r, type_nxt;
  logic [eafr_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]                  id_r, id_nxt;
  logic [7:0]                  status_r, status_nxt;
  logic [7:0]                  rssi_r, rssi_nxt;
  logic [eafr_pkg::PLEN_W-1:0] plen_r, plen_nxt;

  logic [7:0] type_now;
  logic       csum_good;

  assign type_now  = (pos_r == eafr_pkg::POS_TYPE) ? tok.value : type_r;
  assign csum_good = ((eafr_pkg::CSUM_BASE - sum_r) == tok.value);

  always_comb begin
    sum_nxt    = sum_r;
    type_nxt   = type_r;
    pos_nxt    = pos_r;
    id_nxt     = id_r;
    status_nxt = status_r;
    rssi_nxt   = rssi_r;
    plen_nxt   = plen_r;
    res_valid  = 1'b0;
    res        = '0;
    if (tok_take) begin
      unique case (tok.kind)
        eafr_pkg::TOK_START: begin
          sum_nxt    = '0;
          type_nxt   = '0;
          pos_nxt    = '0;
          id_nxt     = '0;
          status_nxt = '0;
          rssi_nxt   = '0;
          plen_nxt   = tok.plen;
        end
        eafr_pkg::TOK_BODY: begin
          sum_nxt  = sum_r + tok.value;
          type_nxt = type_now;
          // Position saturates once the payload region is reached
          if (pos_r != eafr_pkg::POS_PAYLOAD) pos_nxt = pos_r + 1'b1;
          if (type_now == eafr_pkg::TYPE_RX) begin
            if (pos_r == eafr_pkg::POS_RSSI) rssi_nxt = tok.value;
            if (pos_r == eafr_pkg::POS_PAYLOAD) begin
              res_valid        = 1'b1;
              res.kind         = eafr_pkg::KIND_PAYLOAD;
              res.payload_byte = tok.value;
            end
          end else if (type_now == eafr_pkg::TYPE_STATUS) begin
            if (pos_r == eafr_pkg::POS_ID) id_nxt = tok.value;
            else if (pos_r == eafr_pkg::POS_STATUS) status_nxt = tok.value;
          end
        end
        eafr_pkg::TOK_CHECK: begin
          if (type_r == eafr_pkg::TYPE_RX) begin
            res_valid           = 1'b1;
            res.kind            = csum_good ? eafr_pkg::KIND_MSG_GOOD : eafr_pkg::KIND_CSUM_BAD;
            res.signal_strength = rssi_r;
            res.payload_length  = plen_r;
          end else if ((type_r == eafr_pkg::TYPE_STATUS) && csum_good) begin
            res_valid           = 1'b1;
            res.kind            = eafr_pkg::KIND_STATUS_GOOD;
            res.ack_frame_id    = id_r;
            res.delivery_status = status_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      type_r   <= '0;
      pos_r    <= '0;
      id_r     <= '0;
      status_r <= '0;
      rssi_r   <= '0;
      plen_r   <= '0;
    end else begin
      sum_r    <= sum_nxt;
      type_r   <= type_nxt;
      pos_r    <= pos_nxt;
      id_r     <= id_nxt;
      status_r <= status_nxt;
      rssi_r   <= rssi_nxt;
      plen_r   <= plen_nxt;
    end
  end

endmodule

FILE: hw/rtl/escaped_api_frame_receiver.sv
// Path: the token for a byte is registered in the token queue, then decoded by the back end
//   into the result queue, whose head drives the out_ ports; a full result queue holds tokens back.
// Throughput: one byte per cycle while the token queue is not full (in_full low).
// Reset: synchronous active-low rst_n returns the receiver to start-byte hunt and
//   empties both queues; queue storage itself is not cleared.
module escaped_api_frame_receiver #(
  parameter int unsigned MAX_FRAME = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel: one raw serial byte per transfer
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_rx_byte,
  // Result channel
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_payload_byte,
  output logic signed [7:0] out_signal_strength,
  output logic [6:0]        out_payload_length,
  output logic [7:0]        out_ack_frame_id,
  output logic [7:0]        out_delivery_status
);

  localparam int unsigned TOK_W = $bits(eafr_pkg::token_t);
  localparam int unsigned RES_W = $bits(eafr_pkg::result_t);

  logic              in_accept;
  logic              tok_valid;
  eafr_pkg::token_t  tok_in;
  eafr_pkg::token_t  tok_head;
  logic              tok_full;
  logic              tok_empty;
  logic              tok_take;
  logic              res_valid;
  eafr_pkg::result_t res_in;
  eafr_pkg::result_t res_head;
  logic              res_full;

  // Front end: unescape and frame each byte; every transfer yields at most one token.
  // Stall the input only when the token queue is full.
  assign in_full   = tok_full;
  assign in_accept = in_push && !tok_full;

  eafr_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .rx_byte  (in_rx_byte),
    .tok_valid(tok_valid),
    .tok      (tok_in)
  );

  // Token queue between front and back lets each side stall on its own
  eafr_fifo #(
    .W    (TOK_W),
    .DEPTH(eafr_pkg::QUEUE_DEPTH)
  ) u_tok_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (tok_valid),
    .din  (tok_in),
    .full (tok_full),
    .pop  (tok_take),
    .dout (tok_head),
    .empty(tok_empty)
  );

  // Back end: advance one token whenever the result queue has room, so a
  // token that produces a result never finds the result queue full
  assign tok_take = !tok_empty && !res_full;

  eafr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_take (tok_take),
    .tok      (tok_head),
    .res_valid(res_valid),
    .res      (res_in)
  );

  // Result queue: hold finished results until the consumer pops them
  eafr_fifo #(
    .W    (RES_W),
    .DEPTH(eafr_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_valid),
    .din  (res_in),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_head),
    .empty(out_empty)
  );

  assign out_kind            = res_head.kind;
  assign out_payload_byte    = res_head.payload_byte;
  assign out_signal_strength = res_head.signal_strength;
  assign out_payload_length  = res_head.payload_length;
  assign out_ack_frame_id    = res_head.ack_frame_id;
  assign out_delivery_status = res_head.delivery_status;

endmodule
